[rtl/fis_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types and helpers for the fitness index sorter.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned IDX_W = 6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control from the top level to every cell.
    typedef struct packed {
        logic ins;    // insert a new entry this cycle
        logic shift;  // shift the row one place towards cell 0
        logic clear;  // drop all entries
    } cell_ctl_t;

    // Sign fold: ordered doubles compare as unsigned numbers.
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] k;
        if (bits[KEY_W-1]) begin
            k = ~bits;
        end else begin
            k = bits | {1'b1, {(KEY_W-1){1'b0}}};
        end
        return k;
    endfunction

endpackage
`default_nettype wire

[rtl/fis_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fis_cell
// One slot of the sorted row. On insert the cell keeps its entry, takes the
// new one, or takes its left neighbour's, so the row stays sorted and stable.
// ----------------------------------------------------------------------------
module fis_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fis_pkg::cell_ctl_t            ctl,
    input  wire logic [fis_pkg::KEY_W-1:0]     new_bits,
    input  wire logic [fis_pkg::IDX_W-1:0]     new_idx,
    input  wire logic                          left_valid,
    input  wire logic                          left_gt,    // left holds key > new
    input  wire logic [fis_pkg::KEY_W-1:0]     left_bits,
    input  wire logic [fis_pkg::IDX_W-1:0]     left_idx,
    input  wire logic                          right_valid,
    input  wire logic [fis_pkg::KEY_W-1:0]     right_bits,
    input  wire logic [fis_pkg::IDX_W-1:0]     right_idx,
    output logic                               valid,
    output logic                               gt,         // own key > new
    output logic [fis_pkg::KEY_W-1:0]          bits,
    output logic [fis_pkg::IDX_W-1:0]          idx
);

    logic                      valid_reg, valid_next;
    logic [fis_pkg::KEY_W-1:0] bits_reg, bits_next;
    logic [fis_pkg::IDX_W-1:0] idx_reg, idx_next;

    assign gt = valid_reg &&
                (fis_pkg::fold_key(bits_reg) > fis_pkg::fold_key(new_bits));

    always_comb begin
        valid_next = valid_reg;
        bits_next  = bits_reg;
        idx_next   = idx_reg;
        priority if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next = right_valid;
            bits_next  = right_bits;
            idx_next   = right_idx;
        end else if (ctl.ins) begin
            if (gt) begin
                // displaced: take left entry if it also moves, else the new one
                if (left_valid && left_gt) begin
                    bits_next = left_bits;
                    idx_next  = left_idx;
                end else begin
                    bits_next = new_bits;
                    idx_next  = new_idx;
                end
            end else if (!valid_reg) begin
                valid_next = 1'b1;
                if (left_valid && left_gt) begin
                    bits_next = left_bits;
                    idx_next  = left_idx;
                end else if (!left_valid) begin
                    valid_next = 1'b0;
                end else begin
                    bits_next = new_bits;
                    idx_next  = new_idx;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        bits_reg <= bits_next;
        idx_reg  <= idx_next;
    end

    assign valid = valid_reg;
    assign bits  = bits_reg;
    assign idx   = idx_reg;

endmodule
`default_nettype wire

[rtl/fitness_index_sorter.sv]
`default_nettype none
// Each beat is sorted into the cell row in the cycle it is accepted.
// After the last-marked beat the row shifts out one result per cycle from
// the next cycle on while m_tready is high; a stall holds the row.
// Input is held off while the row drains; rate set by the single shift row.
// Reset (aresetn low, synchronous) empties the row and clears the drop flag.
// ----------------------------------------------------------------------------
// fitness_index_sorter
// Stable ascending argsort of doubles in a systolic row of insertion cells.
// ----------------------------------------------------------------------------
module fitness_index_sorter #(
    parameter int unsigned POP_MAX = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] fitness_bits
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [5:0] original_index, [69:6] sorted_fitness
    output logic             m_tlast,   // last_result
    output logic             m_tuser    // overflow
);

    localparam int unsigned CNT_W = $clog2(POP_MAX + 1);
    localparam int unsigned KW = fis_pkg::KEY_W;
    localparam int unsigned IW = fis_pkg::IDX_W;

    fis_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    fis_pkg::cell_ctl_t ctl;

    logic          c_valid [POP_MAX+1];
    logic          c_gt    [POP_MAX];
    logic [KW-1:0] c_bits  [POP_MAX+1];
    logic [IW-1:0] c_idx   [POP_MAX+1];

    logic s_acc, m_acc, room;

    assign room  = count_reg < CNT_W'(POP_MAX);
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // virtual neighbours at both ends: left always "valid, greater" is wrong;
    // cell 0 has no left entry, so left_valid is 1 with left_gt 0 (take new).
    assign c_valid[POP_MAX] = 1'b0;
    assign c_bits[POP_MAX]  = '0;
    assign c_idx[POP_MAX]   = '0;

    for (genvar g = 0; g < POP_MAX; g++) begin : g_cell
        logic          lv, lg;
        logic [KW-1:0] lb;
        logic [IW-1:0] li;
        if (g == 0) begin : g_first
            assign lv = 1'b1;
            assign lg = 1'b0;
            assign lb = '0;
            assign li = '0;
        end else begin : g_rest
            assign lv = c_valid[g-1];
            assign lg = c_gt[g-1];
            assign lb = c_bits[g-1];
            assign li = c_idx[g-1];
        end
        fis_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .new_bits   (s_tdata),
            .new_idx    (IW'(count_reg)),
            .left_valid (lv),
            .left_gt    (lg),
            .left_bits  (lb),
            .left_idx   (li),
            .right_valid(c_valid[g+1]),
            .right_bits (c_bits[g+1]),
            .right_idx  (c_idx[g+1]),
            .valid      (c_valid[g]),
            .gt         (c_gt[g]),
            .bits       (c_bits[g]),
            .idx        (c_idx[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            fis_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    if (room) begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = fis_pkg::ST_EMIT;
                    end
                end
            end
            fis_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_acc) begin
                    ctl.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        drop_next  = 1'b0;
                        state_next = fis_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = fis_pkg::ST_LOAD;
                ctl.clear  = 1'b1;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fis_pkg::ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    assign m_tdata = {2'b00, c_bits[0], c_idx[0]};
    assign m_tlast = count_reg == CNT_W'(1);
    assign m_tuser = drop_reg;

endmodule
`default_nettype wire

[rtl/fis_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fis_checker
// Port-level checks on the sorter's stream behaviour.
// ----------------------------------------------------------------------------
module fis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // no input taken while results are pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");

    // a last input beat starts output next cycle
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid) else $error("no output after last");

    // after the final result, input opens again
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready) else $error("not reopened");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

endmodule

bind fitness_index_sorter fis_checker u_fis_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
`default_nettype wire

[sim/fitness_index_sorter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_index_sorter_test
// Drives populations of double bit patterns into the sorter and checks that
// every run comes back as a stable ascending argsort, with the drop flag set
// for runs that overflowed. Both sides idle at random.
// ----------------------------------------------------------------------------
module fitness_index_sorter_test;

    localparam int unsigned POP = 64;

    typedef struct packed {
        logic [63:0] bits;
        logic        last;
    } fit_beat_t;

    typedef struct packed {
        logic [5:0]  idx;
        logic [63:0] bits;
        logic        last;
        logic        ovf;
    } rank_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    fitness_index_sorter #(.POP_MAX(POP)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fit_beat_t  pending_fits[$];
    rank_beat_t expected_ranks[$];
    int         errors = 0;
    bit         stim_done = 1'b0;

    // predictor state
    logic [63:0] pop_bits[POP];
    int          pop_count = 0;
    bit          pop_dropped = 1'b0;

    function automatic logic [63:0] order_key(logic [63:0] b);
        return b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
    endfunction

    // Stable insertion sort of the loaded run, pushed as expectations.
    task automatic rank_population(input fit_beat_t f);
        logic [63:0] sb[POP];
        logic [5:0]  si[POP];
        logic [63:0] k;
        int j;
        if (pop_count < POP) begin
            pop_bits[pop_count] = f.bits;
            pop_count++;
        end else begin
            pop_dropped = 1'b1;
        end
        if (!f.last) return;
        for (int i = 0; i < pop_count; i++) begin
            k = order_key(pop_bits[i]);
            j = i;
            while (j > 0 && order_key(sb[j-1]) > k) begin
                sb[j] = sb[j-1];
                si[j] = si[j-1];
                j--;
            end
            sb[j] = pop_bits[i];
            si[j] = 6'(i);
        end
        for (int i = 0; i < pop_count; i++)
            expected_ranks.push_back('{si[i], sb[i], i == pop_count - 1, pop_dropped});
        pop_count = 0;
        pop_dropped = 1'b0;
    endtask

    function automatic logic [63:0] rand_double(int mode);
        logic [63:0] b;
        b = {$urandom, $urandom};
        case (mode)
            0: b = b;                                          // raw pattern
            1: b = {b[63], 11'(1023 + $urandom_range(0, 6) - 3), b[51:0]};
            2: b = {$urandom_range(0, 1) == 1, 63'(0)};        // signed zeros
            default: b = {b[63], 11'(1023 + $urandom_range(0, 2)), 52'(0)}; // ties
        endcase
        // keep NaNs out
        if (b[62:52] == 11'h7FF && b[51:0] != 0) b[51:0] = '0;
        return b;
    endfunction

    task automatic add_run(input int n, input int mode);
        for (int i = 0; i < n; i++)
            pending_fits.push_back('{rand_double(mode), i == n - 1});
    endtask

    initial begin
        int sent;
        // directed: extremes, zeros, ties, single entry, full and overflowing store
        pending_fits.push_back('{64'h0000_0000_0000_0000, 1'b0});
        pending_fits.push_back('{64'h8000_0000_0000_0000, 1'b0});
        pending_fits.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
        pending_fits.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b0});
        pending_fits.push_back('{64'h7FF0_0000_0000_0000, 1'b0});
        pending_fits.push_back('{64'hFFF0_0000_0000_0000, 1'b0});
        pending_fits.push_back('{64'h3FF0_0000_0000_0000, 1'b0});
        pending_fits.push_back('{64'h3FF0_0000_0000_0000, 1'b1});
        pending_fits.push_back('{64'hBFF0_0000_0000_0000, 1'b1});
        add_run(5, 3);
        add_run(POP, 0);
        add_run(POP + 3, 1);
        sent = pending_fits.size();
        while (sent < 350) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(POP - 2, POP + 4)
                                            : $urandom_range(1, 12);
            add_run(n, $urandom_range(0, 3));
            sent += n;
        end
        stim_done = 1'b1;
    end

    // driver
    int        send_wait = 0;
    fit_beat_t cur_fit;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rank_population(cur_fit);
                send_wait = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0) send_wait = 0;
            end
            if ((!s_tvalid || s_tready) && send_wait == 0 && pending_fits.size() > 0) begin
                cur_fit = pending_fits.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur_fit.bits;
                s_tlast  <= cur_fit.last;
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end
            if (send_wait > 0 && !(s_tvalid && !s_tready)) send_wait--;
        end
    end

    // monitor and receiver
    int  recv_wait = 0;
    int  hold_off = 0;
    int  beats_seen = 0;
    rank_beat_t exp_rank;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (expected_ranks.size() == 0) begin
                    $display("%0t: unexpected beat idx=%0d bits=%h", $time,
                             m_tdata[5:0], m_tdata[69:6]);
                    errors++;
                end else begin
                    exp_rank = expected_ranks.pop_front();
                    if (m_tdata[5:0] !== exp_rank.idx || m_tdata[69:6] !== exp_rank.bits ||
                        m_tlast !== exp_rank.last || m_tuser !== exp_rank.ovf) begin
                        $display("%0t: expected idx=%0d bits=%h last=%b ovf=%b", $time,
                                 exp_rank.idx, exp_rank.bits, exp_rank.last, exp_rank.ovf);
                        $display("%0t:   actual idx=%0d bits=%h last=%b ovf=%b", $time,
                                 m_tdata[5:0], m_tdata[69:6], m_tlast, m_tuser);
                        errors++;
                    end
                end
                recv_wait = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0) recv_wait = 0;
                // one long stall early on so the input backs up
                if (beats_seen == 40) hold_off = 400;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        @(posedge aclk);
        while (pending_fits.size() > 0 || s_tvalid || expected_ranks.size() > 0)
            @(posedge aclk);
        repeat (2 * POP + 20) @(posedge aclk);
        if (errors == 0 && expected_ranks.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
